[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clock, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/epsnfa_pkg.sv]
// ----------------------------------------------------------------------------
// epsnfa_pkg
// widths, defaults and register indexes for the epsilon elimination block
// ----------------------------------------------------------------------------
package epsnfa_pkg;

   // default sizing of the automaton store
   localparam int DEF_MAX_STATES  = 8;
   localparam int DEF_MAX_SYMBOLS = 8;

   // request and response field widths
   localparam int SRC_W = 3;
   localparam int SYM_W = 3;
   localparam int TGT_W = 8;

   // register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STATES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SYMBOLS = 1'd1;

   localparam logic [CSR_DATA_W-1:0] RST_NUM_STATES  = 4'd8;
   localparam logic [CSR_DATA_W-1:0] RST_NUM_SYMBOLS = 4'd8;

endpackage

[rtl/core/epsilon_nfa_elimination.sv]
// ----------------------------------------------------------------------------
// epsilon_nfa_elimination
// loads an automaton with epsilon moves, then emits the epsilon-free rows
// ----------------------------------------------------------------------------
// usage
//  - request channel (req_*): one transition row per request, one cycle each
//    while idle; symbol 0 rows are the epsilon moves and carry the final flag
//  - a request with req_last_item high is stored and then starts conversion;
//    req_ready stays low until conversion, output and store clearing are done
//  - conversion: the closures are seeded, then closure steps run (one pivot
//    state per cycle, its row read once and or-ed into each row reaching
//    it), then each response walks the move memory's single read port
//    - n = states in use, m = symbols in use
//  - response channel (rsp_*): n*(m-1) responses in state then symbol order,
//    rsp_last_result on the final one; each sits in the output register
//    until taken, and a stalled receiver simply holds the sequencer
//  - after the last response a clearing pass writes zero to all
//    MAX_STATES * 2**clog2(MAX_SYMBOLS) memory rows (64 at default sizing)
//  - reset (synchronous) runs the same clearing pass before the first request
//  - register writes (csr_*) take effect at once; they are read only while
//    converting
// ----------------------------------------------------------------------------
module epsilon_nfa_elimination
   import epsnfa_pkg::*;
#(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SRC_W-1:0]      req_source_state,
   input  logic [SYM_W-1:0]      req_symbol,
   input  logic [TGT_W-1:0]      req_target_mask,
   input  logic                  req_is_final,
   input  logic                  req_last_item,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SRC_W-1:0]      rsp_out_state,
   output logic [SYM_W-1:0]      rsp_out_symbol,
   output logic [TGT_W-1:0]      rsp_out_targets,
   output logic                  rsp_out_final,
   output logic                  rsp_last_result,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RW    = MAX_STATES;                // closure row width
   localparam int SW    = $clog2(MAX_STATES);
   localparam int YW    = $clog2(MAX_SYMBOLS);
   localparam int AW    = SW + YW;
   localparam int DEPTH = MAX_STATES * (1 << YW);
   localparam int NW    = $clog2(MAX_STATES + 1);
   localparam int MW    = $clog2(MAX_SYMBOLS + 1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CINIT = 3'd2;
   localparam logic [2:0] ST_CLOS  = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CSR_DATA_W-1:0] num_states_ff, num_states_in;
   logic [CSR_DATA_W-1:0] num_symbols_ff, num_symbols_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;

   // move memory, one row per (state, symbol)
   logic [TGT_W-1:0]      move_mem [DEPTH];
   logic [TGT_W-1:0]      rd_data_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [TGT_W-1:0]      mem_wdata;

   // epsilon rows and final flags kept in flops for the closure seed
   logic [TGT_W-1:0]      eps_ff [MAX_STATES];
   logic [TGT_W-1:0]      eps_in [MAX_STATES];
   logic [MAX_STATES-1:0] final_ff, final_in;

   // closure rows
   logic [RW-1:0]         clos_ff [MAX_STATES];
   logic [RW-1:0]         clos_in [MAX_STATES];

   // walk counters: idx is the pivot while closing, the state while emitting
   logic [SW-1:0]         idx_ff, idx_in;
   logic [SW-1:0]         r_ff, r_in;
   logic [YW-1:0]         a_ff, a_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  hit_ff, hit_in;
   logic [TGT_W-1:0]      acc_ff, acc_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SRC_W-1:0]      rsp_state_ff, rsp_state_in;
   logic [SYM_W-1:0]      rsp_symbol_ff, rsp_symbol_in;
   logic [TGT_W-1:0]      rsp_targets_ff, rsp_targets_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_last_ff, rsp_last_in;

   // derived values
   logic [NW-1:0]         n_eff;
   logic [MW-1:0]         m_eff;
   logic [SW-1:0]         n_last;
   logic [YW-1:0]         m_last;
   logic [RW-1:0]         keep;
   logic [TGT_W-1:0]      keep8;
   logic [RW-1:0]         row_sel;
   logic                  row_final;
   logic [TGT_W-1:0]      acc_sum;
   logic                  req_fire;
   logic                  ld_hit;
   logic [SW-1:0]         ld_src;
   logic [YW-1:0]         ld_sym;

   // saturate the registers into their legal ranges
   always_comb begin
      if (num_states_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(num_states_ff) > MAX_STATES) begin
         n_eff = NW'(MAX_STATES);
      end else begin
         n_eff = NW'(num_states_ff);
      end
      if (32'(num_symbols_ff) < 2) begin
         m_eff = MW'(2);
      end else if (32'(num_symbols_ff) > MAX_SYMBOLS) begin
         m_eff = MW'(MAX_SYMBOLS);
      end else begin
         m_eff = MW'(num_symbols_ff);
      end
   end

   assign n_last = SW'(n_eff - NW'(1));
   assign m_last = YW'(m_eff - MW'(1));

   // masks of the states in use
   always_comb begin
      for (int i = 0; i < RW; i++) begin
         keep[i] = 32'(i) < 32'(n_eff);
      end
      for (int i = 0; i < TGT_W; i++) begin
         keep8[i] = 32'(i) < 32'(n_eff);
      end
   end

   // single read of the closure rows, shared by closing and emitting
   assign row_sel   = clos_ff[idx_ff];
   assign row_final = |(row_sel & final_ff & keep);
   assign acc_sum   = acc_ff | ((rd_vld_ff && hit_ff) ? rd_data_ff : '0);

   // request decode; rows outside the store are dropped
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign ld_hit    = req_fire && (32'(req_source_state) < MAX_STATES)
                      && (32'(req_symbol) < MAX_SYMBOLS);
   assign ld_src    = SW'(req_source_state);
   assign ld_sym    = YW'(req_symbol);

   // memory write port: clearing pass or load
   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || ld_hit;
      mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : {ld_src, ld_sym};
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : req_target_mask;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         move_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= move_mem[{r_ff, a_ff}];
   end

   // register writes
   always_comb begin
      num_states_in  = num_states_ff;
      num_symbols_in = num_symbols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_STATES:  num_states_in  = csr_wdata;
            CSR_NUM_SYMBOLS: num_symbols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      eps_in         = eps_ff;
      final_in       = final_ff;
      clos_in        = clos_ff;
      idx_in         = idx_ff;
      r_in           = r_ff;
      a_in           = a_ff;
      rd_vld_in      = 1'b0;
      hit_in         = hit_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_state_in   = rsp_state_ff;
      rsp_symbol_in  = rsp_symbol_ff;
      rsp_targets_in = rsp_targets_ff;
      rsp_final_in   = rsp_final_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // wipe epsilon rows and flags, one memory row per cycle
            for (int q = 0; q < MAX_STATES; q++) begin
               eps_in[q] = '0;
            end
            final_in    = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ld_hit && (ld_sym == '0)) begin
               eps_in[ld_src]   = req_target_mask;
               final_in[ld_src] = req_is_final;
            end
            if (req_fire && req_last_item) begin
               state_in = ST_CINIT;
            end
         end
         ST_CINIT: begin
            // each state reaches itself and its direct epsilon targets
            for (int q = 0; q < MAX_STATES; q++) begin
               if (32'(q) < 32'(n_eff)) begin
                  clos_in[q] = ((RW'(1) << q) | RW'(eps_ff[q])) & keep;
               end else begin
                  clos_in[q] = '0;
               end
            end
            idx_in   = '0;
            state_in = ST_CLOS;
         end
         ST_CLOS: begin
            // every row reaching the pivot takes on the pivot's row
            for (int q = 0; q < MAX_STATES; q++) begin
               if (clos_ff[q][idx_ff]) begin
                  clos_in[q] = clos_ff[q] | row_sel;
               end
            end
            if (idx_ff == n_last) begin
               idx_in   = '0;
               a_in     = YW'(1);
               r_in     = '0;
               acc_in   = '0;
               state_in = ST_ACC;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         ST_ACC: begin
            // one memory row per cycle, taken when its state is in the closure
            rd_vld_in = 1'b1;
            hit_in    = row_sel[r_ff];
            acc_in    = acc_sum;
            if (r_ff == n_last) begin
               state_in = ST_WAIT;
            end else begin
               r_in = r_ff + SW'(1);
            end
         end
         ST_WAIT: begin
            rsp_valid_in   = 1'b1;
            rsp_state_in   = SRC_W'(idx_ff);
            rsp_symbol_in  = SYM_W'(a_ff);
            rsp_targets_in = acc_sum & keep8;
            rsp_final_in   = row_final;
            rsp_last_in    = (idx_ff == n_last) && (a_ff == m_last);
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end else begin
                  r_in   = '0;
                  acc_in = '0;
                  if (a_ff == m_last) begin
                     a_in   = YW'(1);
                     idx_in = idx_ff + SW'(1);
                  end else begin
                     a_in = a_ff + YW'(1);
                  end
                  state_in = ST_ACC;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         num_states_ff  <= RST_NUM_STATES;
         num_symbols_ff <= RST_NUM_SYMBOLS;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         num_states_ff  <= num_states_in;
         num_symbols_ff <= num_symbols_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      eps_ff         <= eps_in;
      final_ff       <= final_in;
      clos_ff        <= clos_in;
      idx_ff         <= idx_in;
      r_ff           <= r_in;
      a_ff           <= a_in;
      hit_ff         <= hit_in;
      acc_ff         <= acc_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_symbol_ff  <= rsp_symbol_in;
      rsp_targets_ff <= rsp_targets_in;
      rsp_final_ff   <= rsp_final_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_state   = rsp_state_ff;
   assign rsp_out_symbol  = rsp_symbol_ff;
   assign rsp_out_targets = rsp_targets_ff;
   assign rsp_out_final   = rsp_final_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

[rtl/core/epsnfa_checker.sv]
// ----------------------------------------------------------------------------
// epsnfa_checker
// port-level checks on the epsilon elimination block, bound into its module
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epsnfa_checker
   import epsnfa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [SRC_W-1:0]      rsp_out_state,
   input logic [SYM_W-1:0]      rsp_out_symbol,
   input logic [TGT_W-1:0]      rsp_out_targets,
   input logic                  rsp_out_final,
   input logic                  rsp_last_result
);

   logic                           req_fire;
   logic                           rsp_fire;
   logic                           rsp_stall;
   logic                           chan_closed;
   logic [SRC_W+SYM_W+TGT_W+1:0]   rsp_bundle;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign chan_closed = !req_ready && !rsp_valid;
   assign rsp_bundle  = {rsp_out_state, rsp_out_symbol, rsp_out_targets,
                         rsp_out_final, rsp_last_result};

   // loading and emitting never overlap
   `ASSERT_IMPL(a_no_load_while_emit, rsp_valid, !req_ready, "request taken while emitting")

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_bundle), "response not held")

   // the last request starts conversion
   `ASSERT_NEXT(a_busy_after_last, req_fire && req_last_item, !req_ready, "ready after last")

   // the last response is followed by the clearing pass
   `ASSERT_NEXT(a_clear_after_run, rsp_fire && rsp_last_result, chan_closed, "no clearing pass")

   // epsilon rows are never emitted
   `ASSERT_IMPL(a_no_eps_row, rsp_valid, rsp_out_symbol != SYM_W'(0), "epsilon row emitted")

endmodule

bind epsilon_nfa_elimination epsnfa_checker u_epsnfa_checker (.*);
